### rtl/core/vt4_pkg.sv
// vt4_pkg: shared types, widths and constants of the 4x4 vertex transform core
// no dependencies; used by every file under rtl/core
`default_nettype none

package vt4_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned SUM_W    = 66;
  localparam int unsigned RND_W    = 51;
  localparam int unsigned NUM_W    = 48;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned NUM_ROWS = 4;
  localparam int unsigned DIV_BITS = NUM_W;
  localparam int unsigned ROW_LAT  = 3;
  localparam int unsigned DIV_LAT  = DIV_BITS + 2;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t ONE_Q16 = 32'sh0001_0000;
  localparam word_t S32_MAX = 32'sh7fff_ffff;
  localparam word_t S32_MIN = 32'sh8000_0000;

  typedef enum logic {
    REQ_POINT  = 1'b0,
    REQ_VECTOR = 1'b1
  } req_t;

  // matrix reset value: identity
  localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic valid;
    req_t mode;
  } row_ctl_t;

  typedef struct packed {
    logic  valid;
    req_t  mode;
    logic  zero_w;
    word_t sw;
  } div_ctl_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  zero_w_flag;
  } res_t;

  // clamp a rounded row sum to the 32-bit range
  function automatic word_t sat_word(input logic signed [RND_W-1:0] v);
    word_t r;
    if (v > RND_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < RND_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/vt4_if.sv
// vt4_in_if / vt4_out_if: valid/ready channels of the vertex transform core
// depends on vt4_pkg
`default_nettype none

interface vt4_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  vt4_pkg::word_t    vec_x;
  vt4_pkg::word_t    vec_y;
  vt4_pkg::word_t    vec_z;
  vt4_pkg::word_t    vec_w;
  modport source (output valid, req_type, vec_x, vec_y, vec_z, vec_w, input ready);
  modport sink   (input valid, req_type, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

interface vt4_out_if;
  logic              valid;
  logic              ready;
  vt4_pkg::word_t    out_x;
  vt4_pkg::word_t    out_y;
  vt4_pkg::word_t    out_z;
  vt4_pkg::word_t    out_w;
  logic              zero_w_flag;
  modport source (output valid, out_x, out_y, out_z, out_w, zero_w_flag, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, zero_w_flag, output ready);
endinterface

`default_nettype wire

### rtl/core/vt4_row_lane.sv
// vt4_row_lane: one matrix row, four products, rounded sum, translation, saturation
// depends on vt4_pkg; three register stages, all advanced by en
`default_nettype none

module vt4_row_lane (
  input  wire                            clk,
  input  wire                            en,
  input  vt4_pkg::req_t                  mode,
  input  vt4_pkg::word_t [vt4_pkg::NUM_COLS-1:0] vec,
  input  vt4_pkg::word_t [vt4_pkg::NUM_COLS-1:0] mat,
  output vt4_pkg::word_t                 s
);

  logic signed [vt4_pkg::PROD_W-1:0] prod_r [vt4_pkg::NUM_COLS];
  vt4_pkg::word_t                    trans_r;
  vt4_pkg::word_t                    trans2_r;
  logic signed [vt4_pkg::SUM_W-1:0]  sum_r;
  vt4_pkg::word_t                    s_r;
  logic signed [vt4_pkg::SUM_W-1:0]  rnd;
  logic signed [vt4_pkg::RND_W-1:0]  tot;

  // products; last column is w in vector mode, translation in point mode
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < vt4_pkg::NUM_COLS - 1; c++) begin
        prod_r[c] <= vec[c] * mat[c];
      end
      if (mode == vt4_pkg::REQ_VECTOR) begin
        prod_r[vt4_pkg::NUM_COLS-1] <= vec[vt4_pkg::NUM_COLS-1] * mat[vt4_pkg::NUM_COLS-1];
        trans_r <= '0;
      end else begin
        prod_r[vt4_pkg::NUM_COLS-1] <= '0;
        trans_r <= mat[vt4_pkg::NUM_COLS-1];
      end
    end
  end

  // exact sum of products
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= vt4_pkg::SUM_W'(prod_r[0]) + vt4_pkg::SUM_W'(prod_r[1])
             + vt4_pkg::SUM_W'(prod_r[2]) + vt4_pkg::SUM_W'(prod_r[3]);
      trans2_r <= trans_r;
    end
  end

  // round to nearest, ties up, then add translation and clamp
  always_comb begin
    rnd = (sum_r + vt4_pkg::SUM_W'(32768)) >>> 16;
    tot = vt4_pkg::RND_W'(rnd) + vt4_pkg::RND_W'(trans2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= vt4_pkg::sat_word(tot);
    end
  end

  assign s = s_r;

endmodule

`default_nettype wire

### rtl/core/vt4_div_lane.sv
// vt4_div_lane: pipelined restoring divider, (s * 65536) / sw, one quotient bit a stage
// depends on vt4_pkg; all stages and the output register advanced by en
`default_nettype none

module vt4_div_lane (
  input  wire             clk,
  input  wire             en,
  input  vt4_pkg::word_t  s_in,
  input  vt4_pkg::word_t  sw_in,
  output vt4_pkg::word_t  q_out,
  output vt4_pkg::word_t  s_out
);

  localparam int unsigned N = vt4_pkg::DIV_BITS;

  logic [vt4_pkg::WORD_W-1:0] rem_r [N+1];
  logic [vt4_pkg::NUM_W-1:0]  num_r [N+1];
  logic [vt4_pkg::NUM_W-1:0]  quo_r [N+1];
  logic [vt4_pkg::WORD_W-1:0] dv_r  [N+1];
  logic                       neg_r [N+1];
  vt4_pkg::word_t             sp_r  [N+1];
  vt4_pkg::word_t             q_r;
  vt4_pkg::word_t             s_q_r;

  logic [vt4_pkg::WORD_W-1:0] s_abs;
  logic [vt4_pkg::WORD_W-1:0] sw_abs;
  logic [vt4_pkg::WORD_W:0]   rem_t [N];
  logic                       ge    [N];
  logic [vt4_pkg::WORD_W:0]   diff  [N];
  logic [vt4_pkg::NUM_W-1:0]  qf;
  vt4_pkg::word_t             q_sat;

  // magnitudes of dividend and divisor
  always_comb begin
    s_abs  = s_in[vt4_pkg::WORD_W-1]  ? (~s_in + 1'b1)  : s_in;
    sw_abs = sw_in[vt4_pkg::WORD_W-1] ? (~sw_in + 1'b1) : sw_in;
  end

  // one trial subtract per stage
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rem_t[i] = {rem_r[i], num_r[i][vt4_pkg::NUM_W-1]};
      diff[i]  = rem_t[i] - {1'b0, dv_r[i]};
      ge[i]    = rem_t[i] >= {1'b0, dv_r[i]};
    end
  end

  // stage registers: load at the head, shift one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      num_r[0] <= {s_abs, 16'h0000};
      quo_r[0] <= '0;
      dv_r[0]  <= sw_abs;
      neg_r[0] <= s_in[vt4_pkg::WORD_W-1] ^ sw_in[vt4_pkg::WORD_W-1];
      sp_r[0]  <= s_in;
      for (int i = 0; i < N; i++) begin
        rem_r[i+1] <= ge[i] ? diff[i][vt4_pkg::WORD_W-1:0] : rem_t[i][vt4_pkg::WORD_W-1:0];
        num_r[i+1] <= {num_r[i][vt4_pkg::NUM_W-2:0], 1'b0};
        quo_r[i+1] <= {quo_r[i][vt4_pkg::NUM_W-2:0], ge[i]};
        dv_r[i+1]  <= dv_r[i];
        neg_r[i+1] <= neg_r[i];
        sp_r[i+1]  <= sp_r[i];
      end
    end
  end

  // apply sign and clamp to 32 bits
  always_comb begin
    qf = quo_r[N];
    if (neg_r[N]) begin
      if (qf > vt4_pkg::NUM_W'(48'h0000_8000_0000)) begin
        q_sat = vt4_pkg::S32_MIN;
      end else begin
        q_sat = ~qf[vt4_pkg::WORD_W-1:0] + 1'b1;
      end
    end else begin
      if (qf > vt4_pkg::NUM_W'(48'h0000_7fff_ffff)) begin
        q_sat = vt4_pkg::S32_MAX;
      end else begin
        q_sat = qf[vt4_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= q_sat;
      s_q_r <= sp_r[N];
    end
  end

  assign q_out = q_r;
  assign s_out = s_q_r;

endmodule

`default_nettype wire

### rtl/core/vertex_transform_4x4_core.sv
// vertex_transform_4x4_core: 4x4 Q16.16 vertex transform with perspective divide
// depends on vt4_pkg, vt4_if, vt4_row_lane, vt4_div_lane
//
// usage:
//   in_ch  : one word per vertex (req_type, vec_x..vec_w); point mode takes
//            x,y,z with w = 1.0 and divides by the computed w, vector mode
//            transforms all four components without a divide
//   out_ch : one word per vertex (out_x..out_w, zero_w_flag), in order
//   cfg_*  : eight 64-bit matrix registers, written while the core is idle
// four row lanes run side by side (four multipliers each), then three
// divider lanes, then a merge stage picks quotient, clamp or plain sums.
// a word passes 3 row stages, 50 divider stages and the output register before
// out_ch.valid rises; one vertex per cycle while in_ch.ready is high.
// when out_ch.ready drops, one word parks in a skid register and the whole
// pipeline then holds; in_ch.ready is low only while the skid is full.
// reset (rst_n low, synchronous) loads the identity matrix and empties
// the pipeline; the core needs no warm-up after reset.
`default_nettype none

module vertex_transform_4x4_core (
  input  wire                              clk,
  input  wire                              rst_n,
  vt4_in_if.sink                           in_ch,
  vt4_out_if.source                        out_ch,
  input  wire                              cfg_we,
  input  wire [vt4_pkg::IDX_W-1:0]         cfg_idx,
  input  wire [vt4_pkg::REG_W-1:0]         cfg_data
);

  logic [vt4_pkg::REG_W-1:0] mat_r [vt4_pkg::NUM_REGS];
  vt4_pkg::row_ctl_t         row_ctl_r [vt4_pkg::ROW_LAT];
  vt4_pkg::div_ctl_t         div_ctl_r [vt4_pkg::DIV_LAT];
  vt4_pkg::res_t             out_r;
  vt4_pkg::res_t             skid_r;
  logic                      out_v_r;
  logic                      skid_v_r;

  logic                      en;
  vt4_pkg::word_t [vt4_pkg::NUM_COLS-1:0] vec;
  vt4_pkg::word_t            s    [vt4_pkg::NUM_ROWS];
  vt4_pkg::word_t            q    [vt4_pkg::NUM_ROWS-1];
  vt4_pkg::word_t            sp   [vt4_pkg::NUM_ROWS-1];
  vt4_pkg::div_ctl_t         last;
  vt4_pkg::res_t             res;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign vec = {in_ch.vec_w, in_ch.vec_z, in_ch.vec_y, in_ch.vec_x};

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) begin
        mat_r[i] <= vt4_pkg::MAT_RESET[i];
      end
    end else if (cfg_we) begin
      mat_r[cfg_idx] <= cfg_data;
    end
  end

  // row lanes
  for (genvar r = 0; r < vt4_pkg::NUM_ROWS; r++) begin : g_row
    vt4_pkg::word_t [vt4_pkg::NUM_COLS-1:0] m;
    for (genvar c = 0; c < vt4_pkg::NUM_COLS; c++) begin : g_col
      assign m[c] = mat_r[c*2 + r/2][(r%2)*vt4_pkg::WORD_W +: vt4_pkg::WORD_W];
    end
    vt4_row_lane u_row (
      .clk  (clk),
      .en   (en),
      .mode (vt4_pkg::req_t'(in_ch.req_type)),
      .vec  (vec),
      .mat  (m),
      .s    (s[r])
    );
  end

  // divider lanes for x, y, z
  for (genvar r = 0; r < vt4_pkg::NUM_ROWS - 1; r++) begin : g_div
    vt4_div_lane u_div (
      .clk   (clk),
      .en    (en),
      .s_in  (s[r]),
      .sw_in (s[vt4_pkg::NUM_ROWS-1]),
      .q_out (q[r]),
      .s_out (sp[r])
    );
  end

  // control delay lines beside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vt4_pkg::ROW_LAT; i++) row_ctl_r[i] <= '0;
      for (int i = 0; i < vt4_pkg::DIV_LAT; i++) div_ctl_r[i] <= '0;
    end else if (en) begin
      row_ctl_r[0] <= '{valid: in_ch.valid, mode: vt4_pkg::req_t'(in_ch.req_type)};
      for (int i = 1; i < vt4_pkg::ROW_LAT; i++) row_ctl_r[i] <= row_ctl_r[i-1];
      div_ctl_r[0] <= '{valid:  row_ctl_r[vt4_pkg::ROW_LAT-1].valid,
                        mode:   row_ctl_r[vt4_pkg::ROW_LAT-1].mode,
                        zero_w: s[vt4_pkg::NUM_ROWS-1] == '0,
                        sw:     s[vt4_pkg::NUM_ROWS-1]};
      for (int i = 1; i < vt4_pkg::DIV_LAT; i++) div_ctl_r[i] <= div_ctl_r[i-1];
    end
  end

  // merge: plain sums, quotients or zero-w clamp
  assign last = div_ctl_r[vt4_pkg::DIV_LAT-1];

  function automatic vt4_pkg::word_t sign_clamp(input vt4_pkg::word_t v);
    vt4_pkg::word_t r;
    if (v == '0) begin
      r = '0;
    end else if (v[vt4_pkg::WORD_W-1]) begin
      r = vt4_pkg::S32_MIN;
    end else begin
      r = vt4_pkg::S32_MAX;
    end
    return r;
  endfunction

  always_comb begin
    res = '0;
    case (last.mode)
      vt4_pkg::REQ_VECTOR: begin
        res.x = sp[0];
        res.y = sp[1];
        res.z = sp[2];
        res.w = last.sw;
        res.zero_w_flag = 1'b0;
      end
      vt4_pkg::REQ_POINT: begin
        res.w = vt4_pkg::ONE_Q16;
        res.zero_w_flag = last.zero_w;
        if (last.zero_w) begin
          res.x = sign_clamp(sp[0]);
          res.y = sign_clamp(sp[1]);
          res.z = sign_clamp(sp[2]);
        end else begin
          res.x = q[0];
          res.y = q[1];
          res.z = q[2];
        end
      end
      default: res = '0;
    endcase
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r  <= skid_v_r || (en && last.valid);
      skid_v_r <= 1'b0;
    end else if (en && last.valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (en && last.valid) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_x       = out_r.x;
  assign out_ch.out_y       = out_r.y;
  assign out_ch.out_z       = out_r.z;
  assign out_ch.out_w       = out_r.w;
  assign out_ch.zero_w_flag = out_r.zero_w_flag;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while output is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && out_v_r)
    else $error("skid word lost under stall");

  a_flag_w_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_w_flag |-> out_ch.out_w == vt4_pkg::ONE_Q16)
    else $error("zero-w flag without unit w");

endmodule

`default_nettype wire
